/* rtl/spr_pkg.sv */
// Shared constants, word types and table-port types of the stepper position reply parser.
package spr_pkg;

	// Frame buffer sizing
	localparam int BUFFER_BYTES    = 16;
	localparam int MIN_FRAME_BYTES = 8;
	localparam int HDR_DEPTH       = 7;
	localparam int COUNT_W         = $clog2(BUFFER_BYTES + 1);
	localparam int HDR_IDX_W       = $clog2(HDR_DEPTH);

	// Position table sizing
	localparam int MAX_MOTOR_ID = 32;
	localparam int TABLE_DEPTH  = MAX_MOTOR_ID + 1;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);
	localparam int POS_W        = 32;
	localparam int SID_W        = 6;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_REPLY_CODE = CFG_IDX_W'(1);
	localparam logic [7:0] TERMINATOR_RST = 8'h6B;
	localparam logic [7:0] REPLY_CODE_RST = 8'h0F;

	typedef enum logic {
		OP_RX    = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] rx_byte;
		logic [7:0] query_id;
	} in_word_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_value;
		logic                    position_stored;
		logic [SID_W-1:0]        stored_motor_id;
	} out_word_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [POS_W-1:0]  data;
	} tbl_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} tbl_rd_t;

endpackage

/* rtl/spr_pos_mem.sv */
// Position table memory: one write port, one registered read port, per-entry valid bits.
module spr_pos_mem import spr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tbl_wr_t          wr,
	input  tbl_rd_t          rd,
	output logic [POS_W-1:0] rd_data
);

	logic [POS_W-1:0]       mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [POS_W-1:0]       rd_data_q;
	logic                   rd_valid_q;

	// Write the entry and read the addressed one
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	// Mark written entries; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_valid_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/spr_frame.sv */
// Frame assembly: byte count, header bytes and position reply decode.
module spr_frame import spr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_en,
	input  logic [7:0]       rx_byte,
	input  logic [7:0]       terminator,
	input  logic [7:0]       reply_code,
	output tbl_wr_t          wr,
	output logic [SID_W-1:0] sid
);

	logic [COUNT_W-1:0] count_q;
	logic [7:0]         hdr_q [HDR_DEPTH];
	logic               room;
	logic [COUNT_W-1:0] count_inc;
	logic               is_term;
	logic               id_ok;
	logic               decode;
	logic [POS_W-1:0]   mag;

	// Work out the count this byte leaves before the terminator check
	assign room      = count_q < COUNT_W'(BUFFER_BYTES);
	assign count_inc = room ? count_q + COUNT_W'(1) : '0;
	assign is_term   = rx_byte == terminator;

	// Decode the held header when a long enough frame ends with an in-range id and the reply code
	assign id_ok  = hdr_q[0] <= 8'(MAX_MOTOR_ID);
	assign decode = byte_en && is_term && (count_inc >= COUNT_W'(MIN_FRAME_BYTES))
		&& id_ok && (hdr_q[1] == reply_code);
	assign mag    = {hdr_q[3], hdr_q[4], hdr_q[5], hdr_q[6]};

	always_comb begin
		wr.en   = decode;
		wr.addr = hdr_q[0][ADDR_W-1:0];
		wr.data = (hdr_q[2] != 8'd0) ? (POS_W'(0) - mag) : mag;
		sid     = hdr_q[0][SID_W-1:0];
	end

	// Advance or clear the byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (byte_en) begin
			count_q <= is_term ? '0 : count_inc;
		end
	end

	// Hold the first header bytes of the frame
	always_ff @(posedge clk) begin
		if (byte_en && count_q < COUNT_W'(HDR_DEPTH)) begin
			hdr_q[count_q[HDR_IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

/* rtl/stepper_position_reply_parser.sv */
// Top level of the stepper position reply parser: handshakes, configuration and result word.
//
// Takes one input word per clock cycle while the result register is free or drains, and
// returns exactly one result word for each, in the cycle after it is accepted. A single
// result register holds that word; a new word is taken in any cycle in which the register
// is empty or its word is taken, so words flow back to back while the receiver keeps ready
// high, and the input stalls while a result waits. A received byte updates the frame count
// and header in the same cycle, and a completed position reply writes the 33-entry position
// table then; a query reads the table through its single registered read port. The table
// reads as zero from reset through per-entry valid bits, so there is no clearing pass and
// words are accepted from the first cycle. Configuration writes are always ready; indexes
// other than the terminator byte (0) and reply code (1) are ignored.
module stepper_position_reply_parser import spr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic             acc;
	logic             is_query;
	logic             q_hit;
	logic [7:0]       term_q;
	logic [7:0]       code_q;
	tbl_wr_t          wr;
	tbl_rd_t          rd;
	logic [POS_W-1:0] rd_data;
	logic [SID_W-1:0] sid;
	logic             out_valid_q;
	logic             query_s1;
	logic             hit_s1;
	logic             stored_s1;
	logic [POS_W-1:0] val_s1;
	logic [SID_W-1:0] sid_s1;

	// Accept a word whenever the result register is free or drains this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign is_query  = in_data.opcode == OP_QUERY;
	assign q_hit     = in_data.query_id <= 8'(MAX_MOTOR_ID);
	assign cfg_ready = 1'b1;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERMINATOR_RST;
			code_q <= REPLY_CODE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TERMINATOR: term_q <= cfg_data;
				CFG_REPLY_CODE: code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spr_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (acc && !is_query),
		.rx_byte    (in_data.rx_byte),
		.terminator (term_q),
		.reply_code (code_q),
		.wr         (wr),
		.sid        (sid)
	);

	// Read the table only for an in-range query so the read word holds under stall
	always_comb begin
		rd.en   = acc && is_query && q_hit;
		rd.addr = in_data.query_id[ADDR_W-1:0];
	end

	spr_pos_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// Advance the result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Capture the result fields of the accepted word
	always_ff @(posedge clk) begin
		if (acc) begin
			query_s1  <= is_query;
			hit_s1    <= q_hit;
			stored_s1 <= wr.en;
			val_s1    <= wr.en ? wr.data : '0;
			sid_s1    <= wr.en ? sid : '0;
		end
	end

	// Assemble the result word
	always_comb begin
		out_data.position_value  = query_s1 ? (hit_s1 ? rd_data : '0) : val_s1;
		out_data.position_stored = !query_s1 && stored_s1;
		out_data.stored_motor_id = query_s1 ? '0 : sid_s1;
	end

	assign out_valid = out_valid_q;

endmodule
